// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the range split enumerator.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

// ----- rtl/rse_pkg.sv -----
// Package for the range split enumerator: sequencer states and default constants.
// No dependencies.
`default_nettype none

package rse_pkg;

    localparam int NAREAS_DEF    = 8;
    localparam int RANGE_W       = 16;
    localparam int AREA_CNT_W    = 5;
    localparam logic [AREA_CNT_W-1:0] NUM_AREAS_RST = 5'd8;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_CHK_SINGLE,
        ST_CHK_REST,
        ST_REST_PAIR,
        ST_REST_SWAP,
        ST_FINISH
    } seq_state_t;

endpackage

`default_nettype wire

// ----- rtl/range_split_enumerator.sv -----
// Top level of the range split enumerator: allowed-mask memory and split sequencer.
// Depends on rse_pkg and assert_macros.svh.
//
// After reset the block clears all 2^NAREAS entries of its allowed-mask memory, one
// entry per cycle, with busy high; num_areas writes are taken during that time. A
// write item and a query with a single area set are taken without raising busy. Any
// other query walks the NAREAS mask bits one per cycle while a bit is clear; at a set
// bit it reads the memory for that area and, if allowed, for the rest of the mask, and
// emits the pairs these yield; a closing state ends the query. Results appear on
// result_valid and cannot be stalled; last marks the final transfer of a query.
`default_nettype none

`include "assert_macros.svh"

module range_split_enumerator #(
    parameter int NAREAS = rse_pkg::NAREAS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [rse_pkg::AREA_CNT_W-1:0] cfg_wdata,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          kind,
    input  wire logic [rse_pkg::RANGE_W-1:0]    range_mask,
    input  wire logic                          allowed,
    output logic                               result_valid,
    output logic [rse_pkg::RANGE_W-1:0]         left_range,
    output logic [rse_pkg::RANGE_W-1:0]         right_range,
    output logic                               no_split,
    output logic                               last
);
    import rse_pkg::*;

    localparam int DEPTH = 1 << NAREAS;
    localparam logic [NAREAS-1:0] ONE = NAREAS'(1);

    logic              mem [DEPTH];
    logic              rdata_reg;
    logic              mem_we;
    logic [NAREAS-1:0] mem_waddr;
    logic              mem_wdata;
    logic              mem_re;
    logic [NAREAS-1:0] mem_raddr;

    seq_state_t              state_reg, state_next;
    logic [AREA_CNT_W-1:0]   num_areas_reg;
    logic [NAREAS-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [NAREAS-1:0]       qmask_reg, qmask_next;
    logic [NAREAS-1:0]       single_reg, single_next;
    logic                    pend_vld_reg, pend_vld_next;
    logic [NAREAS-1:0]       pend_l_reg, pend_l_next;
    logic [NAREAS-1:0]       pend_r_reg, pend_r_next;
    logic                    out_vld_reg, out_vld_next;
    logic [NAREAS-1:0]       out_l_reg, out_l_next;
    logic [NAREAS-1:0]       out_r_reg, out_r_next;
    logic                    out_ns_reg, out_ns_next;
    logic                    out_last_reg, out_last_next;

    logic [NAREAS-1:0] area_mask;
    logic [NAREAS-1:0] in_mask;
    logic [NAREAS-1:0] rest;
    logic              in_single;
    logic              rest_multi;
    logic              emit;
    logic [NAREAS-1:0] emit_l;
    logic [NAREAS-1:0] emit_r;

    always_comb
    begin
        for (int i = 0; i < NAREAS; i++)
        begin
            area_mask[i] = (i == 0) || (AREA_CNT_W'(i) < num_areas_reg);
        end
    end

    assign in_mask    = range_mask[NAREAS-1:0] & area_mask;
    assign in_single  = (in_mask != '0) && ((in_mask & (in_mask - ONE)) == '0);
    assign rest       = qmask_reg ^ single_reg;
    assign rest_multi = (rest & (rest - ONE)) != '0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        qmask_next    = qmask_reg;
        single_next   = single_reg;
        pend_vld_next = pend_vld_reg;
        pend_l_next   = pend_l_reg;
        pend_r_next   = pend_r_reg;
        out_vld_next  = 1'b0;
        out_l_next    = out_l_reg;
        out_r_next    = out_r_reg;
        out_ns_next   = 1'b0;
        out_last_next = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = in_mask;
        mem_wdata     = allowed;
        mem_re        = 1'b0;
        mem_raddr     = single_reg;
        emit          = 1'b0;
        emit_l        = single_reg;
        emit_r        = qmask_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = 1'b0;
                clr_cnt_next = clr_cnt_reg + ONE;
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (kind == KIND_WRITE)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        qmask_next    = in_mask;
                        pend_vld_next = 1'b0;
                        single_next   = ONE;
                        if (in_single)
                        begin
                            out_vld_next  = 1'b1;
                            out_l_next    = in_mask;
                            out_r_next    = in_mask;
                            out_last_next = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (single_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if ((qmask_reg & single_reg) != '0)
                begin
                    mem_re     = 1'b1;
                    state_next = ST_CHK_SINGLE;
                end
                else
                begin
                    single_next = single_reg << 1;
                end
            end
            ST_CHK_SINGLE:
            begin
                if (rdata_reg)
                begin
                    emit       = 1'b1;
                    mem_re     = 1'b1;
                    mem_raddr  = rest;
                    state_next = ST_CHK_REST;
                end
                else
                begin
                    single_next = single_reg << 1;
                    state_next  = ST_SCAN;
                end
            end
            ST_CHK_REST:
            begin
                emit   = 1'b1;
                emit_l = qmask_reg;
                emit_r = single_reg;
                if (rdata_reg)
                begin
                    state_next = ST_REST_PAIR;
                end
                else
                begin
                    single_next = single_reg << 1;
                    state_next  = ST_SCAN;
                end
            end
            ST_REST_PAIR:
            begin
                emit   = 1'b1;
                emit_r = rest;
                if (rest_multi)
                begin
                    state_next = ST_REST_SWAP;
                end
                else
                begin
                    single_next = single_reg << 1;
                    state_next  = ST_SCAN;
                end
            end
            ST_REST_SWAP:
            begin
                emit        = 1'b1;
                emit_l      = rest;
                emit_r      = single_reg;
                single_next = single_reg << 1;
                state_next  = ST_SCAN;
            end
            ST_FINISH:
            begin
                out_vld_next  = 1'b1;
                out_last_next = 1'b1;
                pend_vld_next = 1'b0;
                if (pend_vld_reg)
                begin
                    out_l_next = pend_l_reg;
                    out_r_next = pend_r_reg;
                end
                else
                begin
                    out_l_next  = '0;
                    out_r_next  = '0;
                    out_ns_next = 1'b1;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A pair is held back in the pend registers so that the final one can carry last.
        if (emit)
        begin
            if (pend_vld_reg)
            begin
                out_vld_next = 1'b1;
                out_l_next   = pend_l_reg;
                out_r_next   = pend_r_reg;
            end
            pend_vld_next = 1'b1;
            pend_l_next   = emit_l;
            pend_r_next   = emit_r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            num_areas_reg <= NUM_AREAS_RST;
            clr_cnt_reg   <= '0;
            qmask_reg     <= '0;
            single_reg    <= '0;
            pend_vld_reg  <= 1'b0;
            pend_l_reg    <= '0;
            pend_r_reg    <= '0;
            out_vld_reg   <= 1'b0;
            out_l_reg     <= '0;
            out_r_reg     <= '0;
            out_ns_reg    <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                num_areas_reg <= cfg_wdata;
            end
            clr_cnt_reg   <= clr_cnt_next;
            qmask_reg     <= qmask_next;
            single_reg    <= single_next;
            pend_vld_reg  <= pend_vld_next;
            pend_l_reg    <= pend_l_next;
            pend_r_reg    <= pend_r_next;
            out_vld_reg   <= out_vld_next;
            out_l_reg     <= out_l_next;
            out_r_reg     <= out_r_next;
            out_ns_reg    <= out_ns_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = out_vld_reg;
    assign left_range   = RANGE_W'(out_l_reg);
    assign right_range  = RANGE_W'(out_r_reg);
    assign no_split     = out_ns_reg;
    assign last         = out_last_reg;

    `ASSERT_CLK(a_no_split_is_last, clk, rst_n,
        result_valid && no_split |-> last && left_range == '0 && right_range == '0,
        "no_split transfer without last or with nonzero ranges")
    `ASSERT_CLK(a_query_responds, clk, rst_n,
        start && !busy && kind == KIND_QUERY |=> result_valid || busy,
        "accepted query neither produced a result nor started a scan")
    `ASSERT_CLK(a_result_has_cause, clk, rst_n,
        result_valid |-> $past(busy) || $past(start),
        "result transfer while the block was idle")

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for range_split_enumerator: directed and random mask loads and queries.
// Depends on rse_pkg and the RTL of the block; the expected split pairs come from an
// internal predictor of the allowed-mask memory and the split walk.
`default_nettype none

module testbench;
    import rse_pkg::*;

    localparam int NAREAS        = NAREAS_DEF;
    localparam int MAP_DEPTH     = 1 << NAREAS;
    localparam int SETTLE_CYCLES = 1 + 5 * NAREAS + 10;
    localparam int STALL_LIMIT   = 3000;
    localparam int ITEM_GOAL     = 430;

    typedef struct packed {
        logic [RANGE_W-1:0] left_rng;
        logic [RANGE_W-1:0] right_rng;
        logic               no_split;
        logic               last;
    } split_pair_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [AREA_CNT_W-1:0] cfg_wdata;
    logic                  start;
    logic                  kind;
    logic [RANGE_W-1:0]    range_mask;
    logic                  allowed;
    wire                   busy;
    wire                   result_valid;
    wire  [RANGE_W-1:0]    left_range;
    wire  [RANGE_W-1:0]    right_range;
    wire                   no_split;
    wire                   last;

    logic                  allowed_flags [MAP_DEPTH];
    logic [AREA_CNT_W-1:0] area_count;
    split_pair_t           pending_pairs [$];
    int                    failures = 0;
    int                    items_sent = 0;
    int                    stall_cycles = 0;
    bit                    idle_en = 1'b1;

    range_split_enumerator #(
        .NAREAS(NAREAS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .range_mask  (range_mask),
        .allowed     (allowed),
        .result_valid(result_valid),
        .left_range  (left_range),
        .right_range (right_range),
        .no_split    (no_split),
        .last        (last)
    );

    always #5 clk = ~clk;

    function automatic logic [RANGE_W-1:0] active_areas();
        int n;
        n = int'(area_count);
        if (n < 1)
            n = 1;
        if (n > NAREAS)
            n = NAREAS;
        return RANGE_W'((1 << n) - 1);
    endfunction

    function automatic logic mask_allowed(logic [RANGE_W-1:0] m);
        return allowed_flags[m[NAREAS-1:0]];
    endfunction

    function automatic void queue_pair(split_pair_t p);
        pending_pairs.insert(pending_pairs.size(), p);
    endfunction

    function automatic void push_pair(logic [RANGE_W-1:0] l, logic [RANGE_W-1:0] r);
        split_pair_t p;
        p.left_rng  = l;
        p.right_rng = r;
        p.no_split  = 1'b0;
        p.last      = 1'b0;
        queue_pair(p);
    endfunction

    function automatic void enumerate_splits(logic op, logic [RANGE_W-1:0] m_in, logic flag);
        logic [RANGE_W-1:0] m;
        logic [RANGE_W-1:0] single;
        logic [RANGE_W-1:0] rest;
        int                 produced;
        split_pair_t        tail;
        m = m_in & active_areas();
        if (op == KIND_WRITE)
        begin
            allowed_flags[m[NAREAS-1:0]] = flag;
            return;
        end
        produced = pending_pairs.size();
        if ($countones(m) == 1)
        begin
            push_pair(m, m);
        end
        else
        begin
            for (int i = 0; i < RANGE_W; i++)
            begin
                single = RANGE_W'(1) << i;
                if ((m & single) == '0 || !mask_allowed(single))
                    continue;
                push_pair(single, m);
                push_pair(m, single);
                rest = m ^ single;
                if (mask_allowed(rest))
                begin
                    push_pair(single, rest);
                    if ($countones(rest) > 1)
                        push_pair(rest, single);
                end
            end
        end
        if (pending_pairs.size() == produced)
        begin
            tail.left_rng  = '0;
            tail.right_rng = '0;
            tail.no_split  = 1'b1;
            tail.last      = 1'b0;
            queue_pair(tail);
        end
        tail = pending_pairs.pop_back();
        tail.last = 1'b1;
        queue_pair(tail);
    endfunction

    task automatic send_item(logic op, logic [RANGE_W-1:0] m, logic flag);
        while (idle_en && $urandom_range(99) < 20)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        kind       <= op;
        range_mask <= m;
        allowed    <= flag;
        do
            @(posedge clk);
        while (busy);
        enumerate_splits(op, m, flag);
        items_sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_pairs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_area_count(logic [AREA_CNT_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        area_count = value;
    endtask

    task automatic test_reset_defaults();
        send_item(KIND_QUERY, 16'h0000, 1'b0);
        send_item(KIND_QUERY, 16'h0001, 1'b1);
        send_item(KIND_QUERY, 16'h8000, 1'b0);
        send_item(KIND_QUERY, 16'hFFFF, 1'b1);
    endtask

    task automatic test_allowed_writes();
        send_item(KIND_WRITE, 16'h0001, 1'b1);
        send_item(KIND_WRITE, 16'h0002, 1'b1);
        send_item(KIND_QUERY, 16'h0003, 1'b0);
        send_item(KIND_WRITE, 16'h0002, 1'b0);
        send_item(KIND_QUERY, 16'h0003, 1'b1);
        send_item(KIND_WRITE, 16'hFF06, 1'b1);
        send_item(KIND_WRITE, 16'h0004, 1'b1);
        send_item(KIND_QUERY, 16'h0007, 1'b0);
    endtask

    // Every singleton and every seven-area remainder allowed gives the longest query.
    task automatic test_full_split();
        logic [RANGE_W-1:0] full;
        full = active_areas();
        for (int i = 0; i < NAREAS; i++)
        begin
            send_item(KIND_WRITE, RANGE_W'(1) << i, 1'b1);
            send_item(KIND_WRITE, full ^ (RANGE_W'(1) << i), 1'b1);
        end
        send_item(KIND_QUERY, 16'hFFFF, 1'b0);
    endtask

    task automatic random_split_sequence();
        logic [RANGE_W-1:0] q;
        logic [RANGE_W-1:0] single;
        int                 b;
        q = ($urandom_range(3) == 0) ? RANGE_W'($urandom) : RANGE_W'($urandom & $urandom);
        repeat ($urandom_range(1, 3))
        begin
            b = $urandom_range(NAREAS - 1);
            single = RANGE_W'(1) << b;
            send_item(KIND_WRITE, single, $urandom_range(3) != 0);
            send_item(KIND_WRITE, q ^ single, $urandom_range(3) != 0);
        end
        send_item(KIND_QUERY, q, 1'($urandom_range(1)));
    endtask

    task automatic test_area_counts();
        logic [AREA_CNT_W-1:0] counts [7] = '{5'd3, 5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd8};
        int                    goal;
        foreach (counts[p])
        begin
            write_area_count(counts[p]);
            idle_en = (p != 4);
            goal = items_sent + (ITEM_GOAL - items_sent) / (7 - p);
            while (items_sent < goal)
            begin
                if ($urandom_range(4) == 0)
                    send_item(1'($urandom_range(1)), RANGE_W'($urandom),
                              1'($urandom_range(1)));
                else
                    random_split_sequence();
            end
        end
        idle_en = 1'b1;
    endtask

    always @(posedge clk)
    begin
        split_pair_t want;
        if (rst_n && result_valid)
        begin
            if (pending_pairs.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("Unexpected result: left=%h right=%h no_split=%b last=%b",
                             left_range, right_range, no_split, last);
            end
            else
            begin
                want = pending_pairs.pop_front();
                if (want.left_rng !== left_range || want.right_rng !== right_range ||
                    want.no_split !== no_split || want.last !== last)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("Mismatch: exp %h %h ns=%b last=%b, got %h %h ns=%b last=%b",
                                 want.left_rng, want.right_rng, want.no_split, want.last,
                                 left_range, right_range, no_split, last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= '0;
        start      <= 1'b0;
        kind       <= KIND_WRITE;
        range_mask <= '0;
        allowed    <= 1'b0;
        area_count = NUM_AREAS_RST;
        foreach (allowed_flags[i])
            allowed_flags[i] = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_allowed_writes();
        test_full_split();
        test_area_counts();

        drain_results();
        if (failures == 0 && pending_pairs.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/rse_pkg.sv
rtl/range_split_enumerator.sv
dv/testbench.sv
